// ===== src/rlvm_pkg.sv =====
// Shared types and constants for the run list cluster mapper.
package rlvm_pkg;

  // Largest count or offset field that a run header may announce, in bytes.
  localparam logic [3:0] RLVM_MAX_FIELD_BYTES = 4'd8;

  // Depth of the record queue between the parser and the mapping back end.
  localparam int unsigned RLVM_QUEUE_DEPTH = 4;
  localparam int unsigned RLVM_QUEUE_AW = $clog2(RLVM_QUEUE_DEPTH);

  // Result status codes.
  localparam logic [1:0] RLVM_ST_MAPPED      = 2'd0;
  localparam logic [1:0] RLVM_ST_OUT_OF_RANGE = 2'd1;
  localparam logic [1:0] RLVM_ST_NOT_IN_LIST = 2'd2;
  localparam logic [1:0] RLVM_ST_MALFORMED   = 2'd3;

  // What a record from the parser asks the back end to do.
  typedef enum logic [1:0] {
    REC_NONE,
    REC_RUN,
    REC_STAT
  } rec_kind_e;

  // One parsed record. A record with start set reloads the list context.
  typedef struct packed {
    logic        start;
    rec_kind_e   kind;
    logic [1:0]  status;
    logic [62:0] target;
    logic [62:0] low;
    logic [63:0] count;
    logic [63:0] offset;
    logic        sparse;
  } rlvm_rec_t;

endpackage

// ===== src/rlvm_front.sv =====
// Run list parser: assembles header, count and offset bytes into run records.
module rlvm_front
  import rlvm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  run_byte_i,
  input  logic        list_start_i,
  input  logic [62:0] target_vcn_i,
  input  logic [62:0] low_vcn_i,
  input  logic [62:0] high_vcn_i,
  output logic        rec_push_o,
  output rlvm_rec_t   rec_o
);

  // Parser phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_COUNT  = 2'd2;
  localparam logic [1:0] PH_OFFSET = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  count_size_q, count_size_d;
  logic [3:0]  offset_size_q, offset_size_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] count_q, count_d;
  logic [63:0] off_q, off_d;

  logic [3:0]  hdr_cs, hdr_os;
  logic        hdr_bad, range_bad;
  logic [3:0]  idx_inc;
  logic [63:0] byte_shifted;
  logic [63:0] count_new, off_new;

  // Sign-extends a little-endian offset of n bytes (n from 1 to 8) to 64 bits.
  function automatic logic [63:0] sext_off(logic [63:0] v, logic [3:0] n);
    logic        sgn;
    logic [63:0] res;
    sgn = 1'b0;
    res = v;
    for (int j = 0; j < 8; j++) begin
      if (4'(j + 1) == n) begin
        sgn = v[8*j+7];
      end
    end
    for (int j = 0; j < 8; j++) begin
      if (4'(j) >= n) begin
        res[8*j +: 8] = {8{sgn}};
      end
    end
    return res;
  endfunction

  assign hdr_cs    = run_byte_i[3:0];
  assign hdr_os    = run_byte_i[7:4];
  assign hdr_bad   = (hdr_cs > RLVM_MAX_FIELD_BYTES) || (hdr_os > RLVM_MAX_FIELD_BYTES);
  assign range_bad = (target_vcn_i < low_vcn_i) || (target_vcn_i > high_vcn_i);

  // Place the incoming byte at its little-endian position.
  assign idx_inc      = {1'b0, idx_q} + 4'd1;
  assign byte_shifted = {56'd0, run_byte_i} << {idx_q, 3'b000};
  assign count_new    = count_q | byte_shifted;
  assign off_new      = off_q | byte_shifted;

  // Next-state and record generation for one accepted byte.
  always_comb begin
    phase_d       = phase_q;
    count_size_d  = count_size_q;
    offset_size_d = offset_size_q;
    idx_d         = idx_q;
    count_d       = count_q;
    off_d         = off_q;
    rec_push_o    = 1'b0;
    rec_o         = '0;
    rec_o.kind    = REC_NONE;
    rec_o.target  = target_vcn_i;
    rec_o.low     = low_vcn_i;

    if (take_i) begin
      if (list_start_i || (phase_q == PH_HEADER)) begin
        rec_o.start = list_start_i;
        rec_push_o  = list_start_i;
        if (list_start_i && range_bad) begin
          rec_o.kind   = REC_STAT;
          rec_o.status = RLVM_ST_OUT_OF_RANGE;
          phase_d      = PH_IDLE;
        end else if (run_byte_i == 8'd0) begin
          rec_o.kind   = REC_STAT;
          rec_o.status = RLVM_ST_NOT_IN_LIST;
          rec_push_o   = 1'b1;
          phase_d      = PH_IDLE;
        end else if (hdr_bad) begin
          rec_o.kind   = REC_STAT;
          rec_o.status = RLVM_ST_MALFORMED;
          rec_push_o   = 1'b1;
          phase_d      = PH_IDLE;
        end else begin
          count_size_d  = hdr_cs;
          offset_size_d = hdr_os;
          idx_d         = 3'd0;
          count_d       = '0;
          off_d         = '0;
          phase_d       = (hdr_cs != 4'd0) ? PH_COUNT : PH_OFFSET;
        end
      end else begin
        case (phase_q)
          PH_COUNT: begin
            count_d = count_new;
            idx_d   = idx_inc[2:0];
            if (idx_inc >= count_size_q) begin
              idx_d = 3'd0;
              if (offset_size_q != 4'd0) begin
                phase_d = PH_OFFSET;
              end else begin
                // Sparse run ends on its last count byte.
                rec_o.kind   = REC_RUN;
                rec_o.count  = count_new;
                rec_o.sparse = 1'b1;
                rec_push_o   = 1'b1;
                phase_d      = PH_HEADER;
              end
            end
          end
          PH_OFFSET: begin
            off_d = off_new;
            idx_d = idx_inc[2:0];
            if (idx_inc >= offset_size_q) begin
              idx_d        = 3'd0;
              rec_o.kind   = REC_RUN;
              rec_o.count  = count_q;
              rec_o.offset = sext_off(off_new, offset_size_q);
              rec_push_o   = 1'b1;
              phase_d      = PH_HEADER;
            end
          end
          default: begin
            // Idle bytes without a list start are dropped.
          end
        endcase
      end
    end
  end

  // Control state is reset; the accumulators are loaded at each header.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      count_size_q  <= '0;
      offset_size_q <= '0;
      idx_q         <= '0;
    end else begin
      phase_q       <= phase_d;
      count_size_q  <= count_size_d;
      offset_size_q <= offset_size_d;
      idx_q         <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    off_q   <= off_d;
  end

endmodule

// ===== src/rlvm_queue.sv =====
// Short record queue between the parser and the mapping back end.
module rlvm_queue
  import rlvm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rlvm_rec_t rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output rlvm_rec_t rec_o,
  output logic      empty_o
);

  rlvm_rec_t                 mem_q [RLVM_QUEUE_DEPTH];
  logic [RLVM_QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [RLVM_QUEUE_AW:0]    cnt_q;
  logic                      do_push, do_pop;

  assign full_o  = (cnt_q == (RLVM_QUEUE_AW + 1)'(RLVM_QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

// ===== src/rlvm_back.sv =====
// Mapping back end: tracks the cluster bases, tests each run and holds the result word.
module rlvm_back
  import rlvm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  rlvm_rec_t   q_rec_i,
  output logic        q_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [1:0]  status_o,
  output logic [62:0] lcn_o,
  output logic [63:0] remaining_count_o,
  output logic        sparse_o
);

  // List context.
  logic [62:0] target_q;
  logic [63:0] base_q, run_q;

  // Test stage.
  logic        b_valid_q, b_start_q, b_sparse_q, b_ge_q;
  rec_kind_e   b_kind_q;
  logic [1:0]  b_status_q;
  logic [63:0] b_delta_q, b_count_q, b_lcn_q;
  logic        done_q;

  // Result word.
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [62:0] out_lcn_q;
  logic [63:0] out_rem_q;
  logic        out_sparse_q;

  logic        o_ready, b_fire, a_take;
  logic [62:0] eff_target;
  logic [63:0] eff_base, eff_run, new_run, delta, next_base;
  logic        ge;
  logic        eff_done, hit, emit;
  logic [63:0] hit_lcn, hit_rem;

  assign o_ready = !out_valid_q || pop_i;
  assign b_fire  = b_valid_q && o_ready;
  assign a_take  = !q_empty_i && (!b_valid_q || o_ready);
  assign q_pop_o = a_take;

  // Update stage: a list start reloads the context before the record applies.
  assign eff_target = q_rec_i.start ? q_rec_i.target : target_q;
  assign eff_base   = q_rec_i.start ? {1'b0, q_rec_i.low} : base_q;
  assign eff_run    = q_rec_i.start ? 64'd0 : run_q;
  assign new_run    = eff_run + q_rec_i.offset;
  assign next_base  = eff_base + q_rec_i.count;
  assign delta      = {1'b0, eff_target} - eff_base;
  assign ge         = (eff_base <= {1'b0, eff_target});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      base_q   <= '0;
      run_q    <= '0;
    end else if (a_take) begin
      target_q <= eff_target;
      if (q_rec_i.kind == REC_RUN) begin
        base_q <= next_base;
        run_q  <= new_run;
      end else begin
        base_q <= eff_base;
        run_q  <= eff_run;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_take) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      b_start_q  <= q_rec_i.start;
      b_kind_q   <= q_rec_i.kind;
      b_status_q <= q_rec_i.status;
      b_sparse_q <= q_rec_i.sparse;
      b_ge_q     <= ge;
      b_delta_q  <= delta;
      b_count_q  <= q_rec_i.count;
      b_lcn_q    <= new_run;
    end
  end

  // Test stage: once a list has given its result, later records are dropped.
  assign eff_done = b_start_q ? 1'b0 : done_q;
  assign hit      = (b_kind_q == REC_RUN) && b_ge_q && (b_delta_q < b_count_q);
  assign emit     = b_fire && !eff_done && (hit || (b_kind_q == REC_STAT));
  assign hit_lcn  = b_lcn_q + b_delta_q;
  assign hit_rem  = b_count_q - b_delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (b_fire) begin
      done_q <= eff_done || hit || (b_kind_q == REC_STAT);
    end
  end

  // Result word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (b_kind_q == REC_STAT) begin
        out_status_q <= b_status_q;
        out_lcn_q    <= '0;
        out_rem_q    <= '0;
        out_sparse_q <= 1'b0;
      end else begin
        out_status_q <= RLVM_ST_MAPPED;
        out_lcn_q    <= b_sparse_q ? 63'd0 : hit_lcn[62:0];
        out_rem_q    <= hit_rem;
        out_sparse_q <= b_sparse_q;
      end
    end
  end

  assign empty_o           = !out_valid_q;
  assign status_o          = out_status_q;
  assign lcn_o             = out_lcn_q;
  assign remaining_count_o = out_rem_q;
  assign sparse_o          = out_sparse_q;

endmodule

// ===== src/run_list_vcn_mapper.sv =====
// Top level of the run list cluster mapper.
// The mapper takes one run list byte per cycle while the record queue is not full, also
// while a result word waits to be popped. A byte that completes a run holding the target,
// or a header that ends the list or is malformed, yields its result word in order: the
// parser writes its record into the queue at the accepting edge, the back end's update
// stage takes it, and its test stage loads the result word; a stalled result side holds
// both back. A list start checks the target against the attribute range first and aborts
// any list in progress. After a list has produced its result, further bytes give no word
// until the next list start. A four-entry record queue separates the parser from the
// back end, so full rises only when the result side has been stalled for several records.
module run_list_vcn_mapper
  import rlvm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  run_byte_i,
  input  logic        list_start_i,
  input  logic [62:0] target_vcn_i,
  input  logic [62:0] low_vcn_i,
  input  logic [62:0] high_vcn_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [62:0] lcn_o,
  output logic [63:0] remaining_count_o,
  output logic        sparse_o
);

  logic      take;
  logic      rec_push, q_pop, q_empty;
  rlvm_rec_t rec_in, rec_out;

  assign take = push && !full;

  // Parser.
  rlvm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .run_byte_i   (run_byte_i),
    .list_start_i (list_start_i),
    .target_vcn_i (target_vcn_i),
    .low_vcn_i    (low_vcn_i),
    .high_vcn_i   (high_vcn_i),
    .rec_push_o   (rec_push),
    .rec_o        (rec_in)
  );

  // Record queue.
  rlvm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .rec_o   (rec_out),
    .empty_o (q_empty)
  );

  // Mapping back end.
  rlvm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_rec_i           (rec_out),
    .q_pop_o           (q_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .status_o          (status_o),
    .lcn_o             (lcn_o),
    .remaining_count_o (remaining_count_o),
    .sparse_o          (sparse_o)
  );

endmodule

// ===== src/rlvm_checker.sv =====
// Port-level checks for the run list cluster mapper, bound to the top level.
module rlvm_checker
  import rlvm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status_o,
  input logic [62:0] lcn_o,
  input logic [63:0] remaining_count_o,
  input logic        sparse_o
);

  // A waiting word that is not popped stays unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(lcn_o)
                          && $stable(remaining_count_o) && $stable(sparse_o)))
    else $error("result word changed while stalled");

  // A status word carries no mapping.
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != RLVM_ST_MAPPED)) |->
      (lcn_o == 63'd0 && remaining_count_o == 64'd0 && !sparse_o))
    else $error("status word carries mapping fields");

  // A sparse hit is a mapped word with no logical cluster.
  a_sparse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && sparse_o) |-> (status_o == RLVM_ST_MAPPED && lcn_o == 63'd0))
    else $error("sparse word with cluster or status");

  // A target inside a run always leaves at least one cluster in it.
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == RLVM_ST_MAPPED) |-> (remaining_count_o != 64'd0))
    else $error("mapped word with zero remaining count");

endmodule

bind run_list_vcn_mapper rlvm_checker u_rlvm_checker (.*);
